FILE: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge and off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/albg_pkg.sv
package albg_pkg;

  localparam int NUM_COLUMNS = 16;
  localparam int COL_W       = $clog2(NUM_COLUMNS);
  localparam int CNT_W       = $clog2(NUM_COLUMNS + 1);

  localparam int DATA_W      = 16;
  localparam int START_W     = 4;
  localparam int COLUMN_W    = 4;
  localparam int ADDR_W      = 7;
  localparam int CHAR_W      = 8;

  // quantum = range / NUM_COLUMNS + 1 never exceeds this
  localparam int QUANT_MAX   = (2 ** DATA_W - 1) / NUM_COLUMNS + 1;
  localparam int QUANT_W     = $clog2(QUANT_MAX + 1);
  localparam int STEP_W      = $clog2(DATA_W);
  localparam int LEVEL_W     = $clog2(NUM_COLUMNS + 1);

  localparam logic [CHAR_W-1:0]  BLANK_CHAR = CHAR_W'(8'h10);
  localparam logic [CHAR_W-1:0]  FULL_GLYPH = CHAR_W'(7);
  localparam logic [LEVEL_W-1:0] TOP_SPLIT  = LEVEL_W'(9);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ROW = CFG_IDX_W'(1);

  localparam logic [ADDR_W-1:0] FIRST_ROW_RESET  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SECOND_ROW_RESET = ADDR_W'(64);

  function automatic logic [CHAR_W-1:0] top_char(input logic [LEVEL_W-1:0] lvl);
    logic [CHAR_W-1:0] code;
    if (lvl < TOP_SPLIT) code = BLANK_CHAR;
    else                 code = CHAR_W'(lvl - TOP_SPLIT);
    return code;
  endfunction

  function automatic logic [CHAR_W-1:0] bottom_char(input logic [LEVEL_W-1:0] lvl);
    logic [CHAR_W-1:0] code;
    if (lvl > LEVEL_W'(FULL_GLYPH)) code = FULL_GLYPH;
    else if (lvl != '0)             code = CHAR_W'(lvl - LEVEL_W'(1));
    else                            code = BLANK_CHAR;
    return code;
  endfunction

endpackage

FILE: hw/rtl/autoscaled_lcd_bar_graph.sv
// Autoscaled two-row bar graph for a character display. Each request carries
// one 16-bit sample; samples fill a 16-entry ring, one per cycle while idle. The
// request flagged frame_end closes the frame: start_index picks the entry shown
// in column zero, and the block then streams 32 character writes, top row then
// bottom row for each column, last_write set on the final one. Input stays
// stalled while a frame is processed: a min/max scan over the sample memory
// (one read port), a setup step, a divide for the offset, then per column a
// memory read, operand load, divide, encode and two writes. All divides go
// through one shared restoring divider, one quotient bit per cycle. The user
// must see that row base addresses are written through the cfg port only
// while idle; the block itself does not enforce it.
module autoscaled_lcd_bar_graph
  import albg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic [START_W-1:0]   in_start_index,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COLUMN_W-1:0]  out_column,
  output logic [ADDR_W-1:0]    out_ddram_address,
  output logic [CHAR_W-1:0]    out_char_code,
  output logic                 out_last_write,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OFS_START,
    ST_OFS_DIV,
    ST_COL_RD,
    ST_COL_LD,
    ST_COL_DIV,
    ST_ENCODE,
    ST_EMIT_TOP,
    ST_EMIT_BOT
  } state_t;

  state_t              state_r;
  logic [COL_W-1:0]    load_cnt_r;
  logic [CNT_W-1:0]    scan_cnt_r;
  logic [COL_W-1:0]    col_r;
  logic [START_W-1:0]  start_r;
  logic [DATA_W-1:0]   mn_r, mx_r;
  logic [QUANT_W-1:0]  quant_r;
  logic [LEVEL_W-1:0]  offset_r;
  logic [CHAR_W-1:0]   top_code_r, bot_code_r;
  logic [ADDR_W-1:0]   first_base_r, second_base_r;

  // shared divider
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [QUANT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [QUANT_W:0]    trial, diff;

  logic                out_valid_r, out_last_r;
  logic [COLUMN_W-1:0] out_column_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [CHAR_W-1:0]   out_char_r;

  logic [DATA_W-1:0]   mem [NUM_COLUMNS];
  logic [DATA_W-1:0]   rd_data_r;
  logic [COL_W-1:0]    rd_addr;
  logic [CNT_W:0]      ring_sum;
  logic [COL_W-1:0]    ring_idx;

  logic                in_take, out_free, mem_we;
  logic [DATA_W-1:0]   range;
  logic [DATA_W:0]     lvl_sum;
  logic [LEVEL_W-1:0]  level;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign mem_we    = in_take;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_column        = out_column_r;
  assign out_ddram_address = out_addr_r;
  assign out_char_code     = out_char_r;
  assign out_last_write    = out_last_r;

  assign range = mx_r - mn_r;

  always_comb begin
    ring_sum = (CNT_W + 1)'(start_r) + (CNT_W + 1)'(col_r);
    if (ring_sum >= (CNT_W + 1)'(NUM_COLUMNS)) begin
      ring_sum = ring_sum - (CNT_W + 1)'(NUM_COLUMNS);
    end
    ring_idx = ring_sum[COL_W-1:0];
    rd_addr  = (state_r == ST_SCAN) ? scan_cnt_r[COL_W-1:0] : ring_idx;
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DATA_W-1]};
    diff    = trial - {1'b0, quant_r};
    quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    rem_nxt = trial[QUANT_W-1:0];
    if (trial >= {1'b0, quant_r}) begin
      quo_nxt[0] = 1'b1;
      rem_nxt    = diff[QUANT_W-1:0];
    end
  end

  // level = q + N/2 - offset, floored at zero, saturated at N
  always_comb begin
    lvl_sum = {1'b0, quo_r} + (DATA_W + 1)'(NUM_COLUMNS / 2);
    if (lvl_sum > (DATA_W + 1)'(offset_r)) begin
      lvl_sum = lvl_sum - (DATA_W + 1)'(offset_r);
    end else begin
      lvl_sum = '0;
    end
    if (lvl_sum > (DATA_W + 1)'(NUM_COLUMNS)) begin
      level = LEVEL_W'(NUM_COLUMNS);
    end else begin
      level = lvl_sum[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[load_cnt_r] <= in_sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      load_cnt_r    <= '0;
      scan_cnt_r    <= '0;
      col_r         <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
      first_base_r  <= FIRST_ROW_RESET;
      second_base_r <= SECOND_ROW_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIRST_ROW:  first_base_r  <= cfg_data;
          CFG_SECOND_ROW: second_base_r <= cfg_data;
          default: ;
        endcase
      end

      // the emit states drive the output register themselves
      if (out_valid_r && !out_stall && state_r != ST_EMIT_TOP && state_r != ST_EMIT_BOT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            if (in_frame_end) begin
              load_cnt_r <= '0;
              start_r    <= in_start_index;
              scan_cnt_r <= '0;
              state_r    <= ST_SCAN;
            end else if (load_cnt_r == COL_W'(NUM_COLUMNS - 1)) begin
              load_cnt_r <= '0;
            end else begin
              load_cnt_r <= load_cnt_r + COL_W'(1);
            end
          end
        end

        // read data is registered, so it arrives the cycle after its address
        ST_SCAN: begin
          if (scan_cnt_r == CNT_W'(1)) begin
            mn_r <= rd_data_r;
            mx_r <= rd_data_r;
          end else if (scan_cnt_r != '0) begin
            if (rd_data_r < mn_r) mn_r <= rd_data_r;
            if (rd_data_r > mx_r) mx_r <= rd_data_r;
          end
          if (scan_cnt_r == CNT_W'(NUM_COLUMNS)) begin
            state_r <= ST_OFS_START;
          end else begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
        end

        ST_OFS_START: begin
          quant_r <= QUANT_W'(range >> COL_W) + QUANT_W'(1);
          quo_r   <= range >> 1;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_OFS_DIV;
        end

        ST_OFS_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DATA_W - 1)) begin
            offset_r <= quo_nxt[LEVEL_W-1:0];
            col_r    <= '0;
            state_r  <= ST_COL_RD;
          end
        end

        ST_COL_RD: begin
          state_r <= ST_COL_LD;
        end

        ST_COL_LD: begin
          quo_r   <= rd_data_r - mn_r;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_COL_DIV;
        end

        ST_COL_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DATA_W - 1)) begin
            state_r <= ST_ENCODE;
          end
        end

        ST_ENCODE: begin
          top_code_r <= top_char(level);
          bot_code_r <= bottom_char(level);
          state_r    <= ST_EMIT_TOP;
        end

        ST_EMIT_TOP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_column_r <= COLUMN_W'(col_r);
            out_addr_r   <= first_base_r + ADDR_W'(col_r);
            out_char_r   <= top_code_r;
            out_last_r   <= 1'b0;
            state_r      <= ST_EMIT_BOT;
          end
        end

        ST_EMIT_BOT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_column_r <= COLUMN_W'(col_r);
            out_addr_r   <= second_base_r + ADDR_W'(col_r);
            out_char_r   <= bot_code_r;
            out_last_r   <= (col_r == COL_W'(NUM_COLUMNS - 1));
            if (col_r == COL_W'(NUM_COLUMNS - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              col_r   <= col_r + COL_W'(1);
              state_r <= ST_COL_RD;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_frame_end_stalls, clk, rst_n,
    in_take && in_frame_end, in_stall && load_cnt_r == '0,
    "frame end did not start processing")
  `ASSERT_IMPL(a_last_on_final_column, clk, rst_n,
    out_valid && out_last_write,
    out_column == COLUMN_W'(NUM_COLUMNS - 1)
      && out_ddram_address == second_base_r + ADDR_W'(NUM_COLUMNS - 1),
    "last write not on final bottom-row column")
  `ASSERT_IMPL(a_divisor_nonzero, clk, rst_n,
    state_r == ST_OFS_DIV || state_r == ST_COL_DIV, quant_r != '0,
    "divide by zero quantum")
  `ASSERT_NEXT(a_bottom_follows_top, clk, rst_n,
    state_r == ST_EMIT_TOP && out_free,
    out_valid && !out_last_write && state_r == ST_EMIT_BOT,
    "top-row write not followed by bottom-row phase")

endmodule
